@@ rtl/pairwise_gravity_gradient_core_assert.svh @@
// Assertion macros used by the checker of the pairwise gravity gradient core.
`ifndef PAIRWISE_GRAVITY_GRADIENT_CORE_ASSERT_SVH
`define PAIRWISE_GRAVITY_GRADIENT_CORE_ASSERT_SVH

// Check that cons holds at every clock edge where ante holds.
`define PGG_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cond never holds.
`define PGG_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

@@ rtl/pgg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the pairwise gravity gradient core.
package pgg_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int FRAC_BITS      = 16;
   localparam int MANT_W         = 32;
   localparam int EXP_WIDTH      = 11;
   localparam int DEF_SQRT_STEPS = 4;
   localparam int DEF_DIV_STEPS  = 4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic        [COORD_WIDTH-1:0] ucoord_type;
   typedef logic signed [EXP_WIDTH-1:0]   exp_type;

   // pseudo-float: mantissa in [2^31, 2^32) or zero, value m * 2^e
   typedef struct packed {
      logic [MANT_W-1:0] m;
      exp_type           e;
   } pf_type;

   typedef struct packed {
      coord_type  pos_first_x;
      coord_type  pos_first_y;
      coord_type  pos_second_x;
      coord_type  pos_second_y;
      ucoord_type mass_first;
      ucoord_type mass_second;
   } req_type;

   typedef struct packed {
      coord_type grad_first_x;
      coord_type grad_first_y;
      coord_type grad_second_x;
      coord_type grad_second_y;
      logic      coincident;
      logic      saturated;
   } rsp_type;

endpackage

@@ rtl/pgg_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined restoring integer square root, a few result bits per stage.
module pgg_sqrt
   import pgg_pkg::*;
#(
   parameter int STEPS = DEF_SQRT_STEPS,
   parameter int TAG_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [2*MANT_W-1:0] in_rad,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output logic [MANT_W-1:0]   out_root,
   output logic [TAG_W-1:0]    out_tag
);

   localparam int NSTAGE = MANT_W / STEPS;
   localparam int REM_W  = MANT_W + 4;

   logic                valid_ff [NSTAGE];
   logic [REM_W-1:0]    rem_ff   [NSTAGE];
   logic [2*MANT_W-1:0] rad_ff   [NSTAGE];
   logic [MANT_W-1:0]   root_ff  [NSTAGE];
   logic [TAG_W-1:0]    tag_ff   [NSTAGE];

   for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
      logic                valid_src;
      logic [REM_W-1:0]    rem_src, rem_in;
      logic [2*MANT_W-1:0] rad_src, rad_in;
      logic [MANT_W-1:0]   root_src, root_in;
      logic [TAG_W-1:0]    tag_src;

      // pick the beat from the port or from the stage before
      if (g == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign rad_src   = in_rad;
         assign root_src  = '0;
         assign tag_src   = in_tag;
      end else begin : g_next
         assign valid_src = valid_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign rad_src   = rad_ff[g-1];
         assign root_src  = root_ff[g-1];
         assign tag_src   = tag_ff[g-1];
      end

      // take two radicand bits per step, try root*4+1 against the remainder
      always_comb begin
         logic [REM_W-1:0] t;
         logic [REM_W-1:0] trial;
         rem_in  = rem_src;
         rad_in  = rad_src;
         root_in = root_src;
         for (int i = 0; i < STEPS; i++) begin
            t     = {rem_in[REM_W-3:0], rad_in[2*MANT_W-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
            if (t >= trial) begin
               rem_in  = t - trial;
               root_in = {root_in[MANT_W-2:0], 1'b1};
            end else begin
               rem_in  = t;
               root_in = {root_in[MANT_W-2:0], 1'b0};
            end
            rad_in = rad_in << 2;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_src;
         end
         rem_ff[g]  <= rem_in;
         rad_ff[g]  <= rad_in;
         root_ff[g] <= root_in;
         tag_ff[g]  <= tag_src;
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_root  = root_ff[NSTAGE-1];
   assign out_tag   = tag_ff[NSTAGE-1];

endmodule

@@ rtl/pgg_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for quotients known to fit one mantissa.
module pgg_div
   import pgg_pkg::*;
#(
   parameter int STEPS = DEF_DIV_STEPS,
   parameter int TAG_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [2*MANT_W-1:0] in_num,
   input  logic [MANT_W-1:0]   in_den,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output logic [MANT_W-1:0]   out_quot,
   output logic [TAG_W-1:0]    out_tag
);

   localparam int NSTAGE = MANT_W / STEPS;

   logic              valid_ff [NSTAGE];
   logic [MANT_W-1:0] rem_ff   [NSTAGE];
   logic [MANT_W-1:0] low_ff   [NSTAGE];
   logic [MANT_W-1:0] quot_ff  [NSTAGE];
   logic [MANT_W-1:0] den_ff   [NSTAGE];
   logic [TAG_W-1:0]  tag_ff   [NSTAGE];

   for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
      logic              valid_src;
      logic [MANT_W-1:0] rem_src, rem_in;
      logic [MANT_W-1:0] low_src, low_in;
      logic [MANT_W-1:0] quot_src, quot_in;
      logic [MANT_W-1:0] den_src;
      logic [TAG_W-1:0]  tag_src;

      // the upper half of the dividend starts as the remainder
      if (g == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_num[2*MANT_W-1:MANT_W];
         assign low_src   = in_num[MANT_W-1:0];
         assign quot_src  = '0;
         assign den_src   = in_den;
         assign tag_src   = in_tag;
      end else begin : g_next
         assign valid_src = valid_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign low_src   = low_ff[g-1];
         assign quot_src  = quot_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign tag_src   = tag_ff[g-1];
      end

      // shift in one dividend bit per step and subtract where it fits
      always_comb begin
         logic [MANT_W:0] t;
         rem_in  = rem_src;
         low_in  = low_src;
         quot_in = quot_src;
         for (int i = 0; i < STEPS; i++) begin
            t = {rem_in, low_in[MANT_W-1]};
            if (t >= {1'b0, den_src}) begin
               rem_in  = MANT_W'(t - {1'b0, den_src});
               quot_in = {quot_in[MANT_W-2:0], 1'b1};
            end else begin
               rem_in  = t[MANT_W-1:0];
               quot_in = {quot_in[MANT_W-2:0], 1'b0};
            end
            low_in = low_in << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_src;
         end
         rem_ff[g]  <= rem_in;
         low_ff[g]  <= low_in;
         quot_ff[g] <= quot_in;
         den_ff[g]  <= den_src;
         tag_ff[g]  <= tag_src;
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_quot  = quot_ff[NSTAGE-1];
   assign out_tag   = tag_ff[NSTAGE-1];

endmodule

@@ rtl/pairwise_gravity_gradient_core.sv @@
`timescale 1ns / 1ps
// Top level of the pairwise gravity gradient core.
//
// Use: drive req_data with two particle positions and masses and raise start;
// the pair is taken at a rising edge with start high and busy low. busy stays
// low, so a new pair can be taken at every edge. The result beat appears on
// rsp_data with rsp_strobe high for exactly one cycle, after the pair has passed the
// difference, scaling and sum-of-squares stages, the square root, the r*r stage, the
// three parallel dividers, the normalize, product, normalize and convert stages and
// the output register. Throughput is one pair per cycle. Results leave in request
// order. The receiver cannot stall the block; it must take every strobed beat. G must
// be written through csr_valid/csr_data (csr_ready is always high) only while no
// pair is in flight; the block itself does not enforce this. Synchronous reset
// empties the pipeline and sets G to 1.0. Coincident particles give zero gradients
// with the coincident flag; clipped components set the saturated flag.
module pairwise_gravity_gradient_core
   import pgg_pkg::*;
#(
   parameter int SQRT_STEPS = DEF_SQRT_STEPS,
   parameter int DIV_STEPS  = DEF_DIV_STEPS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  ucoord_type csr_data
);

   localparam int LATENCY = 9 + MANT_W / SQRT_STEPS + MANT_W / DIV_STEPS;
   localparam logic [63:0] GRAV_RESET64 = 64'd1 << FRAC_BITS;
   localparam logic [63:0] MAX_POS = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;

   typedef struct packed {
      logic              px;
      logic              py;
      logic              coin;
      logic [MANT_W-2:0] a;
      logic [MANT_W-2:0] b;
      exp_type           er;
      pf_type            gmm;
   } sq_tag_type;

   typedef struct packed {
      logic    coin;
      exp_type e;
   } mag_tag_type;

   typedef struct packed {
      logic       sat;
      ucoord_type val;
   } conv_type;

   function automatic logic [6:0] clz64(input logic [63:0] v);
      logic [6:0] n;
      logic       found;
      n     = 7'd64;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 7'(63 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic pf_type pf_from(input logic [63:0] v);
      logic [6:0]  lz;
      logic [63:0] nv;
      pf_type      r;
      lz  = clz64(v);
      nv  = v << lz;
      r.m = nv[63:MANT_W];
      r.e = exp_type'(MANT_W - int'(lz));
      return r;
   endfunction

   // product of two normalized mantissas leads at bit 63 or 62; truncate the
   // low half first, then shift the kept mantissa up by one
   function automatic pf_type pf_norm_prod(input logic [63:0] p, input exp_type e);
      pf_type r;
      if (p[63]) begin
         r.m = p[63:MANT_W];
         r.e = e;
      end else begin
         r.m = {p[62:MANT_W], 1'b0};
         r.e = exp_type'(e - 1);
      end
      return r;
   endfunction

   function automatic conv_type to_int(input pf_type p);
      logic [63:0] v;
      logic        sat;
      exp_type     ne;
      conv_type    r;
      sat = 1'b0;
      v   = '0;
      ne  = exp_type'(-p.e);
      if (p.m == '0) begin
         v = '0;
      end else if (p.e >= 32) begin
         sat = 1'b1;
         v   = MAX_POS;
      end else if (p.e >= 0) begin
         v = 64'(p.m) << p.e[4:0];
      end else if (p.e > -32) begin
         v = 64'(p.m) >> ne[4:0];
      end
      if (v > MAX_POS) begin
         sat = 1'b1;
         v   = MAX_POS;
      end
      r.sat = sat;
      r.val = v[COORD_WIDTH-1:0];
      return r;
   endfunction

   ucoord_type grav_const_ff;
   logic       accept;

   // stage 1: differences and input normalization
   logic signed [COORD_WIDTH:0] dx, dy;
   ucoord_type ax_in, ay_in;
   logic       px_in, py_in, coin_in;
   logic       s1_valid_ff, s1_px_ff, s1_py_ff, s1_coin_ff;
   ucoord_type s1_ax_ff, s1_ay_ff;
   pf_type     s1_g_ff, s1_m1_ff, s1_m2_ff;

   // stage 2: scale the difference vector, G*m1
   ucoord_type        big;
   logic [6:0]        lz_big;
   logic [63:0]       sa, sb;
   logic [63:0]       gm_p_in;
   logic              s2_valid_ff, s2_px_ff, s2_py_ff, s2_coin_ff;
   logic [MANT_W-2:0] s2_a_ff, s2_b_ff;
   exp_type           s2_er_ff, s2_gm_e_ff;
   logic [63:0]       s2_gm_p_ff;
   pf_type            s2_m2_ff;

   // stage 3: sum of squares, times m2
   pf_type            gm_pf;
   logic [63:0]       n_in, gmm_p_in;
   logic              s3_valid_ff, s3_px_ff, s3_py_ff, s3_coin_ff;
   logic [MANT_W-2:0] s3_a_ff, s3_b_ff;
   exp_type           s3_er_ff, s3_gmm_e_ff;
   logic [63:0]       s3_n_ff, s3_gmm_p_ff;

   // square root
   sq_tag_type        sq_tag_in, sq_tag_out;
   logic              sq_valid;
   logic [MANT_W-1:0] sq_root;

   // stage 5: r*r
   logic [MANT_W-1:0] rm;
   exp_type           er_adj;
   logic [63:0]       rr_p_in;
   logic              s5_valid_ff;
   logic [63:0]       s5_rr_p_ff;
   exp_type           s5_rr_e_ff;
   logic [MANT_W-1:0] s5_rn_ff;
   sq_tag_type        s5_tag_ff;

   // dividers
   pf_type            rr_pf;
   mag_tag_type       mag_tag_in, mag_tag_out;
   logic              mag_valid;
   logic [MANT_W-1:0] mag_q, ux_q, uy_q;
   logic              ux_px, uy_py;

   // stage 7: normalize magnitude and unit components
   pf_type mag_pf_in, ux_pf_in, uy_pf_in;
   logic   s7_valid_ff, s7_px_ff, s7_py_ff, s7_coin_ff;
   pf_type s7_mag_ff, s7_ux_ff, s7_uy_ff;

   // stage 8: magnitude times unit components
   logic        s8_valid_ff, s8_px_ff, s8_py_ff, s8_coin_ff;
   logic [63:0] s8_xp_ff, s8_yp_ff;
   exp_type     s8_xe_ff, s8_ye_ff;

   // stage 9: normalize components
   logic   s9_valid_ff, s9_px_ff, s9_py_ff, s9_coin_ff;
   pf_type s9_x_ff, s9_y_ff;

   // stage 10: convert to integers
   conv_type cx_in, cy_in;
   logic     s10_valid_ff, s10_px_ff, s10_py_ff, s10_coin_ff;
   conv_type s10_x_ff, s10_y_ff;

   // output
   rsp_type rsp_in;
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // hold G, written by the register beat
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_const_ff <= GRAV_RESET64[COORD_WIDTH-1:0];
      end else if (csr_valid & csr_ready) begin
         grav_const_ff <= csr_data;
      end
   end

   // stage 1
   assign dx = {req_data.pos_first_x[COORD_WIDTH-1], req_data.pos_first_x}
             - {req_data.pos_second_x[COORD_WIDTH-1], req_data.pos_second_x};
   assign dy = {req_data.pos_first_y[COORD_WIDTH-1], req_data.pos_first_y}
             - {req_data.pos_second_y[COORD_WIDTH-1], req_data.pos_second_y};
   assign ax_in   = dx[COORD_WIDTH] ? ucoord_type'(-dx) : ucoord_type'(dx);
   assign ay_in   = dy[COORD_WIDTH] ? ucoord_type'(-dy) : ucoord_type'(dy);
   assign px_in   = ~dx[COORD_WIDTH] & (dx != '0);
   assign py_in   = ~dy[COORD_WIDTH] & (dy != '0);
   assign coin_in = (ax_in == '0) & (ay_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_ax_ff   <= ax_in;
      s1_ay_ff   <= ay_in;
      s1_px_ff   <= px_in;
      s1_py_ff   <= py_in;
      s1_coin_ff <= coin_in;
      s1_g_ff    <= pf_from(64'(grav_const_ff));
      s1_m1_ff   <= pf_from(64'(req_data.mass_first));
      s1_m2_ff   <= pf_from(64'(req_data.mass_second));
   end

   // stage 2: bring the larger magnitude to bit 30
   assign big     = (s1_ax_ff > s1_ay_ff) ? s1_ax_ff : s1_ay_ff;
   assign lz_big  = clz64(64'(big));
   assign sa      = 64'(s1_ax_ff) << lz_big;
   assign sb      = 64'(s1_ay_ff) << lz_big;
   assign gm_p_in = s1_g_ff.m * s1_m1_ff.m;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_a_ff    <= sa[63:MANT_W+1];
      s2_b_ff    <= sb[63:MANT_W+1];
      s2_er_ff   <= exp_type'(MANT_W + 1 - int'(lz_big));
      s2_gm_p_ff <= gm_p_in;
      s2_gm_e_ff <= exp_type'(s1_g_ff.e + s1_m1_ff.e + MANT_W);
      s2_m2_ff   <= s1_m2_ff;
      s2_px_ff   <= s1_px_ff;
      s2_py_ff   <= s1_py_ff;
      s2_coin_ff <= s1_coin_ff;
   end

   // stage 3
   assign n_in     = 64'(s2_a_ff) * 64'(s2_a_ff) + 64'(s2_b_ff) * 64'(s2_b_ff);
   assign gm_pf    = pf_norm_prod(s2_gm_p_ff, s2_gm_e_ff);
   assign gmm_p_in = gm_pf.m * s2_m2_ff.m;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_n_ff     <= n_in;
      s3_gmm_p_ff <= gmm_p_in;
      s3_gmm_e_ff <= exp_type'(gm_pf.e + s2_m2_ff.e + MANT_W);
      s3_a_ff     <= s2_a_ff;
      s3_b_ff     <= s2_b_ff;
      s3_er_ff    <= s2_er_ff;
      s3_px_ff    <= s2_px_ff;
      s3_py_ff    <= s2_py_ff;
      s3_coin_ff  <= s2_coin_ff;
   end

   // square root of the scaled squared distance
   always_comb begin
      sq_tag_in.px   = s3_px_ff;
      sq_tag_in.py   = s3_py_ff;
      sq_tag_in.coin = s3_coin_ff;
      sq_tag_in.a    = s3_a_ff;
      sq_tag_in.b    = s3_b_ff;
      sq_tag_in.er   = s3_er_ff;
      sq_tag_in.gmm  = pf_norm_prod(s3_gmm_p_ff, s3_gmm_e_ff);
   end

   pgg_sqrt #(
      .STEPS (SQRT_STEPS),
      .TAG_W ($bits(sq_tag_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_n_ff),
      .in_tag    (sq_tag_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag_out)
   );

   // stage 5: the root lies in [2^30, 2^32), so one shift normalizes it
   assign rm      = sq_root[MANT_W-1] ? sq_root : {sq_root[MANT_W-2:0], 1'b0};
   assign er_adj  = sq_root[MANT_W-1] ? sq_tag_out.er : exp_type'(sq_tag_out.er - 1);
   assign rr_p_in = rm * rm;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= sq_valid;
      end
      s5_rr_p_ff <= rr_p_in;
      s5_rr_e_ff <= exp_type'(er_adj + er_adj + MANT_W);
      s5_rn_ff   <= sq_root;
      s5_tag_ff  <= sq_tag_out;
   end

   // G*m1*m2 / r^2 and the two unit components, side by side
   assign rr_pf           = pf_norm_prod(s5_rr_p_ff, s5_rr_e_ff);
   assign mag_tag_in.coin = s5_tag_ff.coin;
   assign mag_tag_in.e    = exp_type'(s5_tag_ff.gmm.e - rr_pf.e - (MANT_W - 1));

   pgg_div #(
      .STEPS (DIV_STEPS),
      .TAG_W ($bits(mag_tag_type))
   ) u_div_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid_ff),
      .in_num    ({1'b0, s5_tag_ff.gmm.m, {(MANT_W-1){1'b0}}}),
      .in_den    (rr_pf.m),
      .in_tag    (mag_tag_in),
      .out_valid (mag_valid),
      .out_quot  (mag_q),
      .out_tag   (mag_tag_out)
   );

   pgg_div #(
      .STEPS (DIV_STEPS),
      .TAG_W (1)
   ) u_div_ux (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid_ff),
      .in_num    ({2'b00, s5_tag_ff.a, {(MANT_W-1){1'b0}}}),
      .in_den    (s5_rn_ff),
      .in_tag    (s5_tag_ff.px),
      .out_valid (),
      .out_quot  (ux_q),
      .out_tag   (ux_px)
   );

   pgg_div #(
      .STEPS (DIV_STEPS),
      .TAG_W (1)
   ) u_div_uy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid_ff),
      .in_num    ({2'b00, s5_tag_ff.b, {(MANT_W-1){1'b0}}}),
      .in_den    (s5_rn_ff),
      .in_tag    (s5_tag_ff.py),
      .out_valid (),
      .out_quot  (uy_q),
      .out_tag   (uy_py)
   );

   // stage 7: a zero quotient stays zero and marks a zero magnitude
   always_comb begin
      if (mag_q[MANT_W-1]) begin
         mag_pf_in.m = mag_q;
         mag_pf_in.e = mag_tag_out.e;
      end else begin
         mag_pf_in.m = {mag_q[MANT_W-2:0], 1'b0};
         mag_pf_in.e = exp_type'(mag_tag_out.e - 1);
      end
      ux_pf_in   = pf_from(64'(ux_q));
      ux_pf_in.e = exp_type'(ux_pf_in.e - (MANT_W - 1));
      uy_pf_in   = pf_from(64'(uy_q));
      uy_pf_in.e = exp_type'(uy_pf_in.e - (MANT_W - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= mag_valid;
      end
      s7_mag_ff  <= mag_pf_in;
      s7_ux_ff   <= ux_pf_in;
      s7_uy_ff   <= uy_pf_in;
      s7_px_ff   <= ux_px;
      s7_py_ff   <= uy_py;
      s7_coin_ff <= mag_tag_out.coin;
   end

   // stage 8
   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
      s8_xp_ff   <= s7_mag_ff.m * s7_ux_ff.m;
      s8_yp_ff   <= s7_mag_ff.m * s7_uy_ff.m;
      s8_xe_ff   <= exp_type'(s7_mag_ff.e + s7_ux_ff.e + MANT_W);
      s8_ye_ff   <= exp_type'(s7_mag_ff.e + s7_uy_ff.e + MANT_W);
      s8_px_ff   <= s7_px_ff;
      s8_py_ff   <= s7_py_ff;
      s8_coin_ff <= s7_coin_ff;
   end

   // stage 9
   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= s8_valid_ff;
      end
      s9_x_ff    <= pf_norm_prod(s8_xp_ff, s8_xe_ff);
      s9_y_ff    <= pf_norm_prod(s8_yp_ff, s8_ye_ff);
      s9_px_ff   <= s8_px_ff;
      s9_py_ff   <= s8_py_ff;
      s9_coin_ff <= s8_coin_ff;
   end

   // stage 10: clip magnitudes to the largest positive code
   assign cx_in = to_int(s9_x_ff);
   assign cy_in = to_int(s9_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else begin
         s10_valid_ff <= s9_valid_ff;
      end
      s10_x_ff    <= cx_in;
      s10_y_ff    <= cy_in;
      s10_px_ff   <= s9_px_ff;
      s10_py_ff   <= s9_py_ff;
      s10_coin_ff <= s9_coin_ff;
   end

   // output: apply signs, force zero for coincident particles
   always_comb begin
      rsp_in = '0;
      if (s10_coin_ff) begin
         rsp_in.coincident = 1'b1;
      end else begin
         rsp_in.grad_first_x  = s10_px_ff ? coord_type'(s10_x_ff.val)
                                          : coord_type'(-s10_x_ff.val);
         rsp_in.grad_first_y  = s10_py_ff ? coord_type'(s10_y_ff.val)
                                          : coord_type'(-s10_y_ff.val);
         rsp_in.grad_second_x = s10_px_ff ? coord_type'(-s10_x_ff.val)
                                          : coord_type'(s10_x_ff.val);
         rsp_in.grad_second_y = s10_py_ff ? coord_type'(-s10_y_ff.val)
                                          : coord_type'(s10_y_ff.val);
         rsp_in.saturated     = s10_x_ff.sat | s10_y_ff.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s10_valid_ff;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ rtl/pgg_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker of the pairwise gravity gradient core and its bind.
`include "pairwise_gravity_gradient_core_assert.svh"

module pgg_checker
   import pgg_pkg::*;
#(
   parameter int LATENCY = 25
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   localparam coord_type MIN_CODE = coord_type'(1'b1) <<< (COORD_WIDTH - 1);

   // coincident results carry nothing else
   `PGG_ASSERT_NEVER(a_coin_clean, rsp_strobe && rsp_data.coincident && (rsp_data.grad_first_x != 0 || rsp_data.grad_first_y != 0 || rsp_data.saturated), "coincident beat with nonzero gradient")

   // second particle gets the exact negation
   `PGG_ASSERT_IMPLIES(a_negated, rsp_strobe, rsp_data.grad_second_x == coord_type'(-rsp_data.grad_first_x) && rsp_data.grad_second_y == coord_type'(-rsp_data.grad_first_y), "second gradient is not the negation")

   // clipping never yields the minimum code
   `PGG_ASSERT_IMPLIES(a_no_min, rsp_strobe, rsp_data.grad_first_x != MIN_CODE && rsp_data.grad_first_y != MIN_CODE, "gradient holds the minimum code")

   // every result beat follows a request by the fixed latency
   `PGG_ASSERT_IMPLIES(a_latency, rsp_strobe, $past(start && !busy, LATENCY), "result beat without a request")

endmodule

bind pairwise_gravity_gradient_core pgg_checker #(
   .LATENCY (LATENCY)
) u_pgg_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

@@ dv/tb_pairwise_gravity_gradient_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pairwise gravity gradient core.
module tb_pairwise_gravity_gradient_core;
   import pgg_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam longint unsigned MAX_POS = 64'h7FFF_FFFF;

   typedef struct {
      longint unsigned m;
      int              e;
   } fnum_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   ucoord_type csr_data = '0;

   req_type    pend_q[$];
   rsp_type    grad_q[$];
   ucoord_type grav_g = ucoord_type'(1 << FRAC_BITS);
   int         gap_left = 0;
   bit         no_gaps = 0;
   int         mismatches = 0;
   int         pairs_sent = 0;
   int         beats_seen = 0;
   int         sat_seen = 0;
   int         coinc_seen = 0;
   int         csr_writes = 0;

   pairwise_gravity_gradient_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- gradient predictor ----------------
   function automatic fnum_type fn_norm(longint unsigned m, int e);
      fnum_type r;
      if (m == 0) begin
         r.m = 0;
         r.e = 0;
         return r;
      end
      while (m >= 64'h1_0000_0000) begin
         m = m >> 1;
         e++;
      end
      while (m < 64'h8000_0000) begin
         m = m << 1;
         e--;
      end
      r.m = m;
      r.e = e;
      return r;
   endfunction

   function automatic fnum_type fn_mul(fnum_type a, fnum_type b);
      if (a.m == 0 || b.m == 0) return fn_norm(0, 0);
      return fn_norm((a.m * b.m) >> 32, a.e + b.e + 32);
   endfunction

   function automatic fnum_type fn_div(fnum_type a, fnum_type b);
      if (a.m == 0 || b.m == 0) return fn_norm(0, 0);
      return fn_norm((a.m << 31) / b.m, a.e - b.e - 31);
   endfunction

   // truncate to integer, clip to the largest positive code
   function automatic longint unsigned fn_to_int(fnum_type a, ref bit sat);
      longint unsigned v;
      if (a.m == 0) return 0;
      if (a.e >= 32) begin
         sat = 1;
         return MAX_POS;
      end
      if (a.e >= 0) v = a.m << a.e;
      else if (a.e <= -64) v = 0;
      else v = a.m >> (-a.e);
      if (v > MAX_POS) begin
         sat = 1;
         v = MAX_POS;
      end
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned bt = 64'h4000_0000_0000_0000;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
         if (n >= res + bt) begin
            n = n - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // offset-binary compare gives |p - q| and whether p > q
   function automatic longint unsigned sep_mag(coord_type p, coord_type q, ref bit pos);
      longint unsigned op, oq;
      op = {32'd0, ~p[31], p[30:0]};
      oq = {32'd0, ~q[31], q[30:0]};
      pos = op > oq;
      return (op >= oq) ? op - oq : oq - op;
   endfunction

   function automatic rsp_type predict_gradient(req_type q, ucoord_type g);
      rsp_type         r;
      bit              px, py, sat;
      longint unsigned ax, ay, big, a, b, rn, gx, gy;
      int              s, k;
      fnum_type        span_pf, mag;
      r = '0;
      sat = 0;
      ax = sep_mag(q.pos_first_x, q.pos_second_x, px);
      ay = sep_mag(q.pos_first_y, q.pos_second_y, py);
      if (ax == 0 && ay == 0) begin
         r.coincident = 1'b1;
         return r;
      end
      big = (ax > ay) ? ax : ay;
      k = 0;
      while (big != 0) begin
         big = big >> 1;
         k++;
      end
      s = 31 - k;
      if (s >= 0) begin
         a = ax << s;
         b = ay << s;
      end else begin
         a = ax >> (-s);
         b = ay >> (-s);
      end
      rn = int_sqrt(a * a + b * b);
      span_pf = fn_norm(rn, -s);
      mag = fn_mul(fn_mul(fn_norm(g, 0), fn_norm(q.mass_first, 0)),
                   fn_norm(q.mass_second, 0));
      mag = fn_div(mag, fn_mul(span_pf, span_pf));
      gx = fn_to_int(fn_mul(mag, fn_norm((a << 31) / rn, -31)), sat);
      gy = fn_to_int(fn_mul(mag, fn_norm((b << 31) / rn, -31)), sat);
      r.grad_first_x  = px ? coord_type'(gx) : coord_type'(-gx);
      r.grad_first_y  = py ? coord_type'(gy) : coord_type'(-gy);
      r.grad_second_x = px ? coord_type'(-gx) : coord_type'(gx);
      r.grad_second_y = py ? coord_type'(-gy) : coord_type'(gy);
      r.saturated = sat;
      return r;
   endfunction

   // ---------------- pair driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left = 0;
      end else begin
         // log the accepted beat with its expected gradients
         if (start && !busy) begin
            grad_q.push_back(predict_gradient(req_data, grav_g));
            pairs_sent++;
         end
         // advance only when the current slot is free
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pend_q.size() > 0) begin
               req_data <= pend_q.pop_front();
               start <= 1'b1;
               if ($urandom_range(0, 63) == 0) no_gaps = ~no_gaps;
               gap_left = no_gaps ? 0 : $urandom_range(0, 3);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------- result monitor ----------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         beats_seen++;
         if (rsp_data.saturated) sat_seen++;
         if (rsp_data.coincident) coinc_seen++;
         if (grad_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result beat %p", $realtime, rsp_data);
         end else begin
            want = grad_q.pop_front();
            if (rsp_data.grad_first_x !== want.grad_first_x ||
                rsp_data.grad_first_y !== want.grad_first_y ||
                rsp_data.grad_second_x !== want.grad_second_x ||
                rsp_data.grad_second_y !== want.grad_second_y ||
                rsp_data.coincident !== want.coincident ||
                rsp_data.saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch expected %p actual %p",
                           $realtime, want, rsp_data);
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic [31:0] rand_word();
      // spread magnitudes across all bit lengths
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic req_type make_pair(coord_type x1, coord_type y1, coord_type x2,
                                         coord_type y2, ucoord_type m1, ucoord_type m2);
      req_type q;
      q.pos_first_x = x1;
      q.pos_first_y = y1;
      q.pos_second_x = x2;
      q.pos_second_y = y2;
      q.mass_first = m1;
      q.mass_second = m2;
      return q;
   endfunction

   function automatic req_type rand_pair();
      req_type q;
      int      mode;
      mode = $urandom_range(0, 9);
      q.pos_first_x = $urandom;
      q.pos_first_y = $urandom;
      q.mass_first = ($urandom_range(0, 3) == 0) ? $urandom : rand_word();
      q.mass_second = ($urandom_range(0, 3) == 0) ? $urandom : rand_word();
      if (mode < 6) begin
         // neighbors: small random offsets give useful forces
         q.pos_second_x = q.pos_first_x + (($urandom & 1) ? rand_word() : -rand_word());
         q.pos_second_y = q.pos_first_y + (($urandom & 1) ? rand_word() : -rand_word());
      end else if (mode == 6) begin
         // shared axis or shared position
         q.pos_second_x = q.pos_first_x;
         q.pos_second_y = ($urandom & 1) ? q.pos_first_y : coord_type'($urandom);
      end else begin
         q.pos_second_x = $urandom;
         q.pos_second_y = $urandom;
      end
      if ($urandom_range(0, 19) == 0) q.mass_first = '0;
      return q;
   endfunction

   task automatic run_batch(int n);
      for (int i = 0; i < n; i++) pend_q.push_back(rand_pair());
      do @(posedge clock); while (pend_q.size() != 0 || start || grad_q.size() != 0);
   endtask

   task automatic write_grav(ucoord_type g);
      // hold off until the pipeline has drained
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_data <= g;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      grav_g = g;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      coord_type  mx, mn;
      ucoord_type mm;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      mm = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed pairs at the reset value of G
      pend_q.push_back(make_pair(0, 0, 0, 0, 32'h10000, 32'h10000));
      pend_q.push_back(make_pair(mx, mn, mx, mn, mm, mm));
      pend_q.push_back(make_pair(32'h10000, 0, 0, 0, 32'h10000, 32'h10000));
      pend_q.push_back(make_pair(0, 32'h10000, 0, 0, 32'h10000, 32'h10000));
      pend_q.push_back(make_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000));
      pend_q.push_back(make_pair(mx, mx, mn, mn, mm, mm));
      pend_q.push_back(make_pair(mn, mn, mx, mx, 32'h10000, 32'h10000));
      pend_q.push_back(make_pair(mx, 0, mn, 0, mm, 1));
      pend_q.push_back(make_pair(1, 0, 0, 0, mm, mm));
      pend_q.push_back(make_pair(0, 0, 1, 1, mm, mm));
      pend_q.push_back(make_pair(-1, 0, 0, 0, 32'h10000, 32'h10000));
      pend_q.push_back(make_pair(0, 0, 32'h10000, 0, 0, mm));
      pend_q.push_back(make_pair(0, 0, 32'h10000, 0, mm, 0));
      pend_q.push_back(make_pair(0, 0, 0, 0, 0, 0));
      pend_q.push_back(make_pair(3, -4, 0, 0, 1, 1));
      pend_q.push_back(make_pair(mx, mx, mx - 1, mx, mm, mm));
      pend_q.push_back(make_pair(mn, mn, mn, mn + 1, 32'h10000, 32'h10000));
      pend_q.push_back(make_pair(32'h30000, 32'h40000, 0, 0, 32'h50000, 32'h20000));
      pend_q.push_back(make_pair(-32'sh30000, 32'h40000, 0, 0, 1, mm));
      pend_q.push_back(make_pair(32'h1, 32'h7FFF_0000, 0, 0, mm, mm));
      run_batch(300);

      // sweep G through its extremes and a few ordinary values
      write_grav('0);
      pend_q.push_back(make_pair(32'h10000, 0, 0, 0, mm, mm));
      run_batch(100);
      write_grav(32'hFFFF_FFFF);
      run_batch(300);
      write_grav(32'h1);
      run_batch(300);
      write_grav($urandom);
      run_batch(300);
      write_grav(32'h10000);
      run_batch(300);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (grad_q.size() != 0) begin
         mismatches += grad_q.size();
         $display("%0d expected results never arrived", grad_q.size());
      end
      $display("Covered %0d pairs over %0d G settings, %0d result beats checked.",
               pairs_sent, csr_writes + 1, beats_seen);
      $display("Seen %0d saturated and %0d coincident results, %0d mismatches.",
               sat_seen, coinc_seen, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------- watchdog ----------------
   initial begin
      #10_000_000;
      $display("Timeout with %0d pairs pending and %0d results outstanding",
               pend_q.size(), grad_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ pairwise_gravity_gradient_core.f @@
+incdir+rtl
rtl/pgg_pkg.sv
rtl/pgg_sqrt.sv
rtl/pgg_div.sv
rtl/pairwise_gravity_gradient_core.sv
rtl/pgg_checker.sv
dv/tb_pairwise_gravity_gradient_core.sv
